/* design/record_exchange_sorter_defines.svh */
// ----------------------------------------------------------------------------
// Record exchange sorter: assertion macros
// Shared assertion helpers; they expect clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef RECORD_EXCHANGE_SORTER_DEFINES_SVH
`define RECORD_EXCHANGE_SORTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define RES_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: prop");
// A condition that must be followed by another one in the next cycle.
`define RES_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed: cond then nxt");
`else
`define RES_ASSERT(lbl, prop)
`define RES_ASSERT_NEXT(lbl, cond, nxt)
`endif

`endif

/* design/res_pkg.sv */
// ----------------------------------------------------------------------------
// Record exchange sorter package
// Field widths, operation and order codes shared by the sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package res_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int NAME_CHARS_DEF  = 16;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int POP_W     = 40;
    localparam int ORDER_W   = 2;
    localparam int IDX_OUT_W = 6;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR = 2'd0,
        OP_END  = 2'd1,
        OP_SORT = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [ORDER_W-1:0] {
        ORD_NAME_ASC = 2'd0,
        ORD_NAME_DSC = 2'd1,
        ORD_POP_ASC  = 2'd2,
        ORD_POP_DSC  = 2'd3
    } order_t;

endpackage

`default_nettype wire

/* design/record_exchange_sorter.sv */
// ----------------------------------------------------------------------------
// Record exchange sorter
// Loads named records with populations and emits them in a selected order.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per beat: s_tuser is the operation
//   (name byte, end of record, sort), s_tdata the name byte and population.
//   Load beats are taken one per cycle while idle. A sort beat starts a run
//   that fills the order table, then walks every pair i < j, comparing by
//   population or by name. The order and name memories have one read port
//   each. Each record is then emitted as the master stream allows. s_tready
//   is low for the whole run. A sort with no records gives one beat with
//   empty_set and tlast set. The master side has one output register: a
//   stalled receiver holds the beat and the emit sequence waits on it.
//   cfg_data sets the sort order and is always ready. Reset clears the
//   record count and flags; the memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module record_exchange_sorter #(
    parameter int MAX_RECORDS = res_pkg::MAX_RECORDS_DEF,
    parameter int NAME_CHARS  = res_pkg::NAME_CHARS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // s_tdata: char_code[7:0], population[47:8]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [res_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: op[1:0]
    input  wire logic [res_pkg::OP_W-1:0]        s_tuser,
    // m_tdata: record_index[5:0], pop_value[45:6], name_cut[46],
    // records_dropped[47], empty_set[48], zero fill[55:49]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [res_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [res_pkg::ORDER_W-1:0]     cfg_data
);

    import res_pkg::*;

    `include "record_exchange_sorter_defines.svh"

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int CC_W  = $clog2(NAME_CHARS + 1);
    localparam int NA_W  = $clog2(MAX_RECORDS * NAME_CHARS);
    localparam int REC_W = POP_W + CC_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_EMPTY, S_INIT, S_RDI, S_RDI2, S_J0, S_J1, S_J2, S_J3,
        S_N0, S_N1, S_N2, S_SWAP, S_WI, S_E0, S_E1, S_E2
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CC_W-1:0]     char_reg;
    logic                over_reg;
    logic                cut_reg;
    order_t              order_reg;
    logic [CNT_W-1:0]    i_reg;
    logic [CNT_W-1:0]    j_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic [IDX_W-1:0]    b_reg;
    logic [POP_W-1:0]    a_pop_reg;
    logic [CC_W-1:0]     a_len_reg;
    logic [POP_W-1:0]    b_pop_reg;
    logic [CC_W-1:0]     b_len_reg;
    logic [CC_W-1:0]     k_reg;
    logic [CHAR_W-1:0]   ca_reg;
    logic                swap_reg;
    logic [IDX_W-1:0]    r_reg;
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    // Memory ports.
    logic                name_we;
    logic [NA_W-1:0]     name_waddr;
    logic [NA_W-1:0]     name_raddr;
    logic [CHAR_W-1:0]   name_rdata;
    logic                rec_we;
    logic [REC_W-1:0]    rec_wdata;
    logic [IDX_W-1:0]    rec_raddr;
    logic [REC_W-1:0]    rec_rdata;
    logic                ord_we;
    logic [IDX_W-1:0]    ord_waddr;
    logic [IDX_W-1:0]    ord_wdata;
    logic [IDX_W-1:0]    ord_raddr;
    logic [IDX_W-1:0]    ord_rdata;

    op_t                 in_op;
    logic [CHAR_W-1:0]   in_char;
    logic [POP_W-1:0]    in_pop;
    logic                in_beat;
    logic                out_free;
    logic                emit_now;
    logic                store_full;
    logic [CC_W-1:0]     len_min;
    logic [POP_W-1:0]    rd_pop;
    logic [CC_W-1:0]     rd_len;
    logic                rd_cut;
    logic                name_first;

    assign in_op      = op_t'(s_tuser);
    assign in_char    = s_tdata[CHAR_W-1:0];
    assign in_pop     = s_tdata[CHAR_W +: POP_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_beat    = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign emit_now   = out_free && ((state_reg == S_EMPTY) || (state_reg == S_E2));
    assign store_full = (count_reg == CNT_W'(MAX_RECORDS));
    assign len_min    = (a_len_reg < b_len_reg) ? a_len_reg : b_len_reg;
    assign rd_pop     = rec_rdata[POP_W-1:0];
    assign rd_len     = rec_rdata[POP_W +: CC_W];
    assign rd_cut     = rec_rdata[REC_W-1];
    assign name_first = (order_reg == ORD_NAME_ASC) || (order_reg == ORD_NAME_DSC);

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

    function automatic logic [NA_W-1:0] name_addr(
        input logic [IDX_W-1:0] rec,
        input logic [CC_W-1:0]  pos
    );
        return NA_W'(rec) * NA_W'(NAME_CHARS) + NA_W'(pos);
    endfunction

    always_comb
    begin
        name_we    = in_beat && (in_op == OP_CHAR) && !store_full
                     && (char_reg != CC_W'(NAME_CHARS));
        name_waddr = name_addr(count_reg[IDX_W-1:0], char_reg);
        name_raddr = (state_reg == S_N1) ? name_addr(b_reg, k_reg)
                                         : name_addr(cur_reg, k_reg);

        rec_we    = in_beat && (in_op == OP_END) && !store_full;
        rec_wdata = {cut_reg, char_reg, in_pop};
        unique case (state_reg)
            S_J2:    rec_raddr = b_reg;
            S_E1:    rec_raddr = ord_rdata;
            S_E2:    rec_raddr = r_reg;
            default: rec_raddr = cur_reg;
        endcase

        ord_we    = 1'b0;
        ord_waddr = i_reg[IDX_W-1:0];
        ord_wdata = cur_reg;
        unique case (state_reg)
            S_INIT:
            begin
                ord_we    = 1'b1;
                ord_wdata = i_reg[IDX_W-1:0];
            end
            S_SWAP:
            begin
                ord_we    = swap_reg;
                ord_waddr = j_reg[IDX_W-1:0];
            end
            S_WI:    ord_we = 1'b1;
            default: ord_we = 1'b0;
        endcase
        ord_raddr = (state_reg == S_J0) ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    end

    res_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_RECORDS * NAME_CHARS)) u_name_ram (
        .clk     (clk),
        .wr_en   (name_we),
        .wr_addr (name_waddr),
        .wr_data (in_char),
        .rd_addr (name_raddr),
        .rd_data (name_rdata)
    );

    res_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_we),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (rec_wdata),
        .rd_addr (rec_raddr),
        .rd_data (rec_rdata)
    );

    res_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RECORDS)) u_ord_ram (
        .clk     (clk),
        .wr_en   (ord_we),
        .wr_addr (ord_waddr),
        .wr_data (ord_wdata),
        .rd_addr (ord_raddr),
        .rd_data (ord_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            char_reg    <= '0;
            over_reg    <= 1'b0;
            cut_reg     <= 1'b0;
            order_reg   <= ORD_NAME_ASC;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= order_t'(cfg_data);
            end
            // A new beat is loaded as soon as the previous one has left.
            m_valid_reg <= emit_now || (m_valid_reg && !m_tready);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        unique case (in_op)
                            OP_CHAR:
                            begin
                                if (!store_full)
                                begin
                                    if (char_reg != CC_W'(NAME_CHARS))
                                        char_reg <= char_reg + 1'b1;
                                    else
                                        cut_reg <= 1'b1;
                                end
                            end
                            OP_END:
                            begin
                                if (store_full)
                                    over_reg <= 1'b1;
                                else
                                    count_reg <= count_reg + 1'b1;
                                char_reg <= '0;
                                cut_reg  <= 1'b0;
                            end
                            OP_SORT:
                            begin
                                i_reg <= '0;
                                if (count_reg == '0)
                                    state_reg <= S_EMPTY;
                                else
                                    state_reg <= S_INIT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        m_last_reg  <= 1'b1;
                        m_data_reg  <= OUT_DATA_W'({1'b1, over_reg, 1'b0,
                                                    {POP_W{1'b0}}, {IDX_OUT_W{1'b0}}});
                        count_reg   <= '0;
                        char_reg    <= '0;
                        over_reg    <= 1'b0;
                        cut_reg     <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                S_INIT:
                begin
                    if (i_reg + 1'b1 == count_reg)
                    begin
                        i_reg <= '0;
                        // A single record is already in order.
                        state_reg <= (count_reg == CNT_W'(1)) ? S_E0 : S_RDI;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_RDI:
                begin
                    state_reg <= S_RDI2;
                end
                S_RDI2:
                begin
                    cur_reg   <= ord_rdata;
                    j_reg     <= i_reg + 1'b1;
                    state_reg <= S_J0;
                end
                S_J0:
                begin
                    state_reg <= S_J1;
                end
                S_J1:
                begin
                    b_reg     <= ord_rdata;
                    state_reg <= S_J2;
                end
                S_J2:
                begin
                    a_pop_reg <= rd_pop;
                    a_len_reg <= rd_len;
                    state_reg <= S_J3;
                end
                S_J3:
                begin
                    b_pop_reg <= rd_pop;
                    b_len_reg <= rd_len;
                    k_reg     <= '0;
                    if (name_first)
                    begin
                        state_reg <= S_N0;
                    end
                    else
                    begin
                        swap_reg  <= (order_reg == ORD_POP_ASC) ? (a_pop_reg > rd_pop)
                                                                : (a_pop_reg < rd_pop);
                        state_reg <= S_SWAP;
                    end
                end
                S_N0:
                begin
                    if (k_reg == len_min)
                    begin
                        // Equal prefix: the shorter name is the lesser one.
                        swap_reg  <= (order_reg == ORD_NAME_ASC) ? (a_len_reg > b_len_reg)
                                                                 : (a_len_reg < b_len_reg);
                        state_reg <= S_SWAP;
                    end
                    else
                    begin
                        state_reg <= S_N1;
                    end
                end
                S_N1:
                begin
                    ca_reg    <= name_rdata;
                    state_reg <= S_N2;
                end
                S_N2:
                begin
                    if (ca_reg != name_rdata)
                    begin
                        swap_reg  <= (order_reg == ORD_NAME_ASC) ? (ca_reg > name_rdata)
                                                                 : (ca_reg < name_rdata);
                        state_reg <= S_SWAP;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_N0;
                    end
                end
                S_SWAP:
                begin
                    if (swap_reg)
                    begin
                        cur_reg <= b_reg;
                    end
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= (j_reg + 1'b1 == count_reg) ? S_WI : S_J0;
                end
                S_WI:
                begin
                    if (CNT_W'(i_reg + 2'd2) == count_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_E0;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_RDI;
                    end
                end
                S_E0:
                begin
                    state_reg <= S_E1;
                end
                S_E1:
                begin
                    r_reg     <= ord_rdata;
                    state_reg <= S_E2;
                end
                S_E2:
                begin
                    if (out_free)
                    begin
                        m_last_reg  <= (i_reg + 1'b1 == count_reg);
                        m_data_reg  <= OUT_DATA_W'({1'b0, over_reg, rd_cut, rd_pop,
                                                    IDX_OUT_W'(r_reg)});
                        if (i_reg + 1'b1 == count_reg)
                        begin
                            count_reg <= '0;
                            char_reg  <= '0;
                            over_reg  <= 1'b0;
                            cut_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_E0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `RES_ASSERT(a_count_range, count_reg <= CNT_W'(MAX_RECORDS))
    `RES_ASSERT(a_char_range, char_reg <= CC_W'(NAME_CHARS))
    `RES_ASSERT(a_pair_order, (state_reg == S_J0 || state_reg == S_SWAP) |-> (j_reg > i_reg))
    `RES_ASSERT_NEXT(a_empty_last, in_beat && in_op == OP_SORT && count_reg == '0,
                     state_reg == S_EMPTY)

endmodule

`default_nettype wire

/* design/res_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module res_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
